>>> rtl/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Text console renderer package
// Shared constants, codes and word layouts of the text console renderer.
// ----------------------------------------------------------------------------
package tcr_pkg;

   // default geometry
   localparam int GLYPH_WIDTH_DEF  = 8;
   localparam int GLYPH_HEIGHT_DEF = 16;
   localparam int MAX_WIDTH_DEF    = 640;
   localparam int MAX_HEIGHT_DEF   = 480;

   // pixel store word: eight one-bit pixels, lowest bit first
   localparam int WORD_BITS  = 8;
   localparam int WORD_SHIFT = 3;

   // field widths
   localparam int ACTION_BITS = 2;
   localparam int CODE_BITS   = 8;
   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 9;
   localparam int GROW_BITS   = 4;
   localparam int GBITS_BITS  = 8;
   localparam int COLOR_BITS  = 24;
   localparam int GLYPH_MSB   = 7;

   localparam int REQ_USER_BITS = 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [COLOR_BITS-1:0] LIT_COLOR    = 24'hFFFFFF;
   localparam logic [CODE_BITS-1:0]  CODE_NEWLINE = 8'd10;
   localparam logic [CODE_BITS-1:0]  CODE_RETURN  = 8'd13;
   localparam logic [COL_BITS-1:0]   WIDTH_RESET  = 10'd640;
   localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 9'd480;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUT   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COL_BITS-1:0] width;
      logic [ROW_BITS-1:0] height;
   } screen_type;

   typedef struct packed {
      action_type            action;
      logic [CODE_BITS-1:0]  char_code;
      logic [COL_BITS-1:0]   pixel_x;
      logic [ROW_BITS-1:0]   pixel_y;
      logic [GROW_BITS-1:0]  glyph_row;
      logic [GBITS_BITS-1:0] glyph_bits;
   } request_type;

   typedef struct packed {
      logic [COL_BITS-1:0]   cursor_col;
      logic [ROW_BITS-1:0]   cursor_row;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  scrolled;
   } response_type;

endpackage

>>> rtl/text_console_renderer_top.sv
// ----------------------------------------------------------------------------
// Text console renderer
// Character console over a one-bit pixel store with a loadable glyph store.
// ----------------------------------------------------------------------------
// Words arrive on the req_ channel: req_tuser carries the action (put char,
// read pixel, load glyph row, clear screen), req_tdata the operands. Each
// word produces one rsp_ word with the cursor after the word, the colour of
// a read pixel and a scroll flag. One word is worked on at a time; the next
// is taken once the result sits in the output register.
// Pixels are packed eight to a word of the pixel RAM, which has one read and
// one write port. A glyph row load writes the glyph store; a pixel read
// forms the row offset, reads the word and picks the bit; newline and return
// move the cursor; a printable char ORs each visible glyph row into one
// or two pixel words; a scroll reads two source words and the target word
// for each screen word and writes it back; a clear zeroes every word and
// homes the cursor. After reset every word of the pixel RAM is swept to zero
// with req_tready low; CSR writes are taken throughout. A stalled rsp_ word
// holds; the block accepts one more word and parks its result.
// Write csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
module text_console_renderer_top #(
   parameter int GLYPH_WIDTH  = tcr_pkg::GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = tcr_pkg::GLYPH_HEIGHT_DEF,
   parameter int MAX_WIDTH    = tcr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = tcr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // action[1:0]
   input  logic [tcr_pkg::REQ_USER_BITS-1:0]  req_tuser,
   // char_code[7:0], pixel_x[17:8], pixel_y[26:18], glyph_row[30:27],
   // glyph_bits[38:31], zero[39]
   input  logic [tcr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cursor_col[9:0], cursor_row[18:10], pixel_color[42:19], scrolled[43],
   // zero[47:44]
   output logic [tcr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [tcr_pkg::CSR_IDX_BITS-1:0]   csr_wr_index,
   input  logic [tcr_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   import tcr_pkg::*;

   localparam int PIX_WORDS   = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;
   localparam int PAW         = $clog2(PIX_WORDS);
   localparam int GLYPH_WORDS = 256 * GLYPH_HEIGHT;
   localparam int GAW         = $clog2(GLYPH_WORDS);
   localparam int RSP_PAD     = RSP_DATA_BITS - COL_BITS - ROW_BITS - COLOR_BITS - 1;

   logic [COL_BITS-1:0] width_ff, width_in;
   logic [ROW_BITS-1:0] height_ff, height_in;
   screen_type          screen;
   request_type         req;
   response_type        rsp;

   logic                  pix_wr_en;
   logic [PAW-1:0]        pix_wr_addr;
   logic [WORD_BITS-1:0]  pix_wr_data;
   logic [PAW-1:0]        pix_rd_addr;
   logic [WORD_BITS-1:0]  pix_rd_data;
   logic                  glyph_wr_en;
   logic [GAW-1:0]        glyph_wr_addr;
   logic [GBITS_BITS-1:0] glyph_wr_data;
   logic [GAW-1:0]        glyph_rd_addr;
   logic [GBITS_BITS-1:0] glyph_rd_data;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_wr_index))
            REG_WIDTH:  width_in  = csr_wr_data[COL_BITS-1:0];
            REG_HEIGHT: height_in = csr_wr_data[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamp the programmed size to what the store and a glyph allow
   always_comb begin
      if (int'(width_ff) < GLYPH_WIDTH) begin
         screen.width = COL_BITS'(GLYPH_WIDTH);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         screen.width = COL_BITS'(MAX_WIDTH);
      end else begin
         screen.width = width_ff;
      end
      if (int'(height_ff) < GLYPH_HEIGHT) begin
         screen.height = ROW_BITS'(GLYPH_HEIGHT);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         screen.height = ROW_BITS'(MAX_HEIGHT);
      end else begin
         screen.height = height_ff;
      end
   end

   assign req.action     = action_type'(req_tuser[ACTION_BITS-1:0]);
   assign req.char_code  = req_tdata[7:0];
   assign req.pixel_x    = req_tdata[17:8];
   assign req.pixel_y    = req_tdata[26:18];
   assign req.glyph_row  = req_tdata[30:27];
   assign req.glyph_bits = req_tdata[38:31];

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp.scrolled, rsp.pixel_color,
                       rsp.cursor_row, rsp.cursor_col};

   tcr_ram #(
      .DATA_BITS (WORD_BITS),
      .DEPTH     (PIX_WORDS)
   ) u_pixel_ram (
      .clock      (clock),
      .wr_en      (pix_wr_en),
      .wr_addr    (pix_wr_addr),
      .wr_data    (pix_wr_data),
      .rd_addr    (pix_rd_addr),
      .rd_data_ff (pix_rd_data)
   );

   tcr_ram #(
      .DATA_BITS (GBITS_BITS),
      .DEPTH     (GLYPH_WORDS)
   ) u_glyph_ram (
      .clock      (clock),
      .wr_en      (glyph_wr_en),
      .wr_addr    (glyph_wr_addr),
      .wr_data    (glyph_wr_data),
      .rd_addr    (glyph_rd_addr),
      .rd_data_ff (glyph_rd_data)
   );

   tcr_ctrl #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .screen        (screen),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req           (req),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp),
      .pix_wr_en     (pix_wr_en),
      .pix_wr_addr   (pix_wr_addr),
      .pix_wr_data   (pix_wr_data),
      .pix_rd_addr   (pix_rd_addr),
      .pix_rd_data   (pix_rd_data),
      .glyph_wr_en   (glyph_wr_en),
      .glyph_wr_addr (glyph_wr_addr),
      .glyph_wr_data (glyph_wr_data),
      .glyph_rd_addr (glyph_rd_addr),
      .glyph_rd_data (glyph_rd_data)
   );

endmodule

>>> rtl/tcr_ram.sv
// ----------------------------------------------------------------------------
// Text console renderer RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcr_ram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data_ff
);

   logic [DATA_BITS-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

>>> rtl/tcr_ctrl.sv
// ----------------------------------------------------------------------------
// Text console renderer sequencer
// Walks the pixel and glyph stores: paint, scroll, clear, pixel read, load.
// ----------------------------------------------------------------------------
module tcr_ctrl #(
   parameter int GLYPH_WIDTH  = tcr_pkg::GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = tcr_pkg::GLYPH_HEIGHT_DEF,
   parameter int MAX_WIDTH    = tcr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = tcr_pkg::MAX_HEIGHT_DEF,
   localparam int PIX_WORDS   = (MAX_WIDTH * MAX_HEIGHT + tcr_pkg::WORD_BITS - 1)
                                / tcr_pkg::WORD_BITS,
   localparam int PAW         = $clog2(PIX_WORDS),
   localparam int GLYPH_WORDS = 256 * GLYPH_HEIGHT,
   localparam int GAW         = $clog2(GLYPH_WORDS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcr_pkg::screen_type               screen,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tcr_pkg::request_type              req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tcr_pkg::response_type             rsp,
   output logic                              pix_wr_en,
   output logic [PAW-1:0]                    pix_wr_addr,
   output logic [tcr_pkg::WORD_BITS-1:0]     pix_wr_data,
   output logic [PAW-1:0]                    pix_rd_addr,
   input  logic [tcr_pkg::WORD_BITS-1:0]     pix_rd_data,
   output logic                              glyph_wr_en,
   output logic [GAW-1:0]                    glyph_wr_addr,
   output logic [tcr_pkg::GBITS_BITS-1:0]    glyph_wr_data,
   output logic [GAW-1:0]                    glyph_rd_addr,
   input  logic [tcr_pkg::GBITS_BITS-1:0]    glyph_rd_data
);

   import tcr_pkg::*;

   localparam int BAW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int RCW  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int PYW  = ROW_BITS + 1;
   localparam int XT   = COL_BITS + 2;
   localparam int YT   = ROW_BITS + 2;
   localparam int SPAN = 2 * WORD_BITS;

   typedef enum logic [17:0] {
      ST_BOOT    = 18'h00001,
      ST_IDLE    = 18'h00002,
      ST_CLEAR   = 18'h00004,
      ST_GLYPH   = 18'h00008,
      ST_MASK    = 18'h00010,
      ST_PRD     = 18'h00020,
      ST_PWR     = 18'h00040,
      ST_CURSOR  = 18'h00080,
      ST_SC_SIZE = 18'h00100,
      ST_SC_BAND = 18'h00200,
      ST_SC_RD0  = 18'h00400,
      ST_SC_RD1  = 18'h00800,
      ST_SC_RD2  = 18'h01000,
      ST_SC_WR   = 18'h02000,
      ST_RMUL    = 18'h04000,
      ST_RRD     = 18'h08000,
      ST_RDATA   = 18'h10000,
      ST_DONE    = 18'h20000
   } state_type;

   state_type            state_ff, state_in;
   request_type          req_ff, req_in;
   response_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_BITS-1:0]  cx_ff, cx_in;
   logic [ROW_BITS-1:0]  cy_ff, cy_in;
   logic [RCW-1:0]       row_ff, row_in;
   logic [BAW-1:0]       prod_ff, prod_in;
   logic [BAW-1:0]       band_ff, band_in;
   logic [BAW-1:0]       keep_ff, keep_in;
   logic [SPAN-1:0]      mask_ff, mask_in;
   logic [PAW-1:0]       word_ff, word_in;
   logic                 half_ff, half_in;
   logic                 rowok_ff, rowok_in;
   logic [PAW-1:0]       wcnt_ff, wcnt_in;
   logic [PAW-1:0]       last_ff, last_in;
   logic [WORD_BITS-1:0] src0_ff, src0_in;
   logic [WORD_BITS-1:0] src1_ff, src1_in;
   logic                 inrange_ff, inrange_in;
   logic [WORD_SHIFT-1:0] bit_ff, bit_in;
   logic                 hit_ff, hit_in;
   logic                 scrolled_ff, scrolled_in;

   logic [PYW-1:0]       py;
   logic [BAW-1:0]       base;
   logic [BAW-1:0]       read_base;
   logic [BAW-1:0]       src_word;
   logic [SPAN-1:0]      pair;
   logic [SPAN-1:0]      paint_mask;
   logic                 last_row;
   logic                 is_nl;
   logic                 is_cr;
   logic [XT-1:0]        x_curs;
   logic [YT-1:0]        y_curs;
   logic                 need_scroll;

   function automatic logic [PAW-1:0] clamp_word(input logic [BAW-1:0] v);
      if (v > BAW'(PIX_WORDS - 1)) begin
         clamp_word = PAW'(PIX_WORDS - 1);
      end else begin
         clamp_word = v[PAW-1:0];
      end
   endfunction

   // bits of word k that lie below bit address lim
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [PAW-1:0] k,
                                                     input logic [BAW-1:0] lim);
      logic [BAW-1:0]        lim_word;
      logic [WORD_SHIFT-1:0] lim_bit;
      lim_word = lim >> WORD_SHIFT;
      lim_bit  = lim[WORD_SHIFT-1:0];
      if (BAW'(k) < lim_word) begin
         low_mask = '1;
      end else if (BAW'(k) == lim_word) begin
         low_mask = (WORD_BITS'(1) << lim_bit) - WORD_BITS'(1);
      end else begin
         low_mask = '0;
      end
   endfunction

   assign py        = PYW'(cy_ff) + PYW'(row_ff);
   assign base      = prod_ff + BAW'(cx_ff);
   assign read_base = prod_ff + BAW'(req_ff.pixel_x);
   assign src_word  = BAW'(wcnt_ff) + (band_ff >> WORD_SHIFT);
   assign pair      = {src1_ff, src0_ff} >> band_ff[WORD_SHIFT-1:0];
   assign last_row  = (row_ff == RCW'(GLYPH_HEIGHT - 1));
   assign glyph_rd_addr = GAW'(req_ff.char_code) * GAW'(GLYPH_HEIGHT) + GAW'(row_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // lit pixels of the current glyph row inside the screen width, placed at the bit offset
   always_comb begin
      paint_mask = '0;
      for (int c = 0; c < GLYPH_WIDTH; c++) begin
         if (glyph_rd_data[GLYPH_MSB-c] &&
             (XT'(cx_ff) + XT'(c) < XT'(screen.width))) begin
            paint_mask[int'(base[WORD_SHIFT-1:0]) + c] = 1'b1;
         end
      end
   end

   // cursor advance, wrap and scroll decision
   always_comb begin
      is_nl = (req_ff.char_code == CODE_NEWLINE);
      is_cr = (req_ff.char_code == CODE_RETURN);
      if (is_nl || is_cr) begin
         x_curs = '0;
      end else begin
         x_curs = XT'(cx_ff) + XT'(GLYPH_WIDTH);
      end
      y_curs = YT'(cy_ff) + (is_nl ? YT'(GLYPH_HEIGHT) : YT'(0));
      if (x_curs + XT'(GLYPH_WIDTH) > XT'(screen.width)) begin
         x_curs = '0;
         y_curs = y_curs + YT'(GLYPH_HEIGHT);
      end
      need_scroll = (y_curs + YT'(GLYPH_HEIGHT) > YT'(screen.height));
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      row_in       = row_ff;
      prod_in      = prod_ff;
      band_in      = band_ff;
      keep_in      = keep_ff;
      mask_in      = mask_ff;
      word_in      = word_ff;
      half_in      = half_ff;
      rowok_in     = rowok_ff;
      wcnt_in      = wcnt_ff;
      last_in      = last_ff;
      src0_in      = src0_ff;
      src1_in      = src1_ff;
      inrange_in   = inrange_ff;
      bit_in       = bit_ff;
      hit_in       = hit_ff;
      scrolled_in  = scrolled_ff;

      pix_wr_en     = 1'b0;
      pix_wr_addr   = wcnt_ff;
      pix_wr_data   = '0;
      pix_rd_addr   = wcnt_ff;
      glyph_wr_en   = 1'b0;
      glyph_wr_addr = GAW'(req.char_code) * GAW'(GLYPH_HEIGHT) + GAW'(req.glyph_row);
      glyph_wr_data = req.glyph_bits;

      case (state_ff)
         ST_BOOT, ST_CLEAR: begin
            pix_wr_en = 1'b1;
            wcnt_in   = wcnt_ff + PAW'(1);
            if (wcnt_ff == PAW'(PIX_WORDS - 1)) begin
               wcnt_in = '0;
               if (state_ff == ST_CLEAR) begin
                  cx_in    = '0;
                  cy_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req;
               hit_in      = 1'b0;
               scrolled_in = 1'b0;
               row_in      = '0;
               wcnt_in     = '0;
               case (req.action)
                  ACT_PUT: begin
                     if (req.char_code == CODE_NEWLINE || req.char_code == CODE_RETURN) begin
                        state_in = ST_CURSOR;
                     end else begin
                        state_in = ST_GLYPH;
                     end
                  end
                  ACT_READ:  state_in = ST_RMUL;
                  ACT_LOAD: begin
                     glyph_wr_en = (int'(req.glyph_row) < GLYPH_HEIGHT);
                     state_in    = ST_DONE;
                  end
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_GLYPH: begin
            rowok_in = (py < PYW'(screen.height));
            prod_in  = BAW'(py) * BAW'(screen.width);
            state_in = ST_MASK;
         end
         ST_MASK: begin
            mask_in = paint_mask;
            word_in = PAW'(base >> WORD_SHIFT);
            half_in = (paint_mask[WORD_BITS-1:0] == '0);
            if (rowok_ff && paint_mask != '0) begin
               state_in = ST_PRD;
            end else if (last_row) begin
               state_in = ST_CURSOR;
            end else begin
               row_in   = row_ff + RCW'(1);
               state_in = ST_GLYPH;
            end
         end
         ST_PRD: begin
            pix_rd_addr = word_ff + PAW'(half_ff);
            state_in    = ST_PWR;
         end
         ST_PWR: begin
            pix_wr_en   = 1'b1;
            pix_wr_addr = word_ff + PAW'(half_ff);
            pix_wr_data = pix_rd_data | (half_ff ? mask_ff[SPAN-1:WORD_BITS]
                                                 : mask_ff[WORD_BITS-1:0]);
            if (!half_ff && mask_ff[SPAN-1:WORD_BITS] != '0) begin
               half_in  = 1'b1;
               state_in = ST_PRD;
            end else if (last_row) begin
               state_in = ST_CURSOR;
            end else begin
               row_in   = row_ff + RCW'(1);
               state_in = ST_GLYPH;
            end
         end
         ST_CURSOR: begin
            cx_in = COL_BITS'(x_curs);
            if (need_scroll) begin
               cy_in       = ROW_BITS'(int'(screen.height) - GLYPH_HEIGHT);
               scrolled_in = 1'b1;
               state_in    = ST_SC_SIZE;
            end else begin
               cy_in    = ROW_BITS'(y_curs);
               state_in = ST_DONE;
            end
         end
         ST_SC_SIZE: begin
            prod_in  = BAW'(screen.width) * BAW'(screen.height);
            band_in  = BAW'(screen.width) * BAW'(GLYPH_HEIGHT);
            state_in = ST_SC_BAND;
         end
         ST_SC_BAND: begin
            keep_in  = prod_ff - band_ff;
            last_in  = PAW'((prod_ff - BAW'(1)) >> WORD_SHIFT);
            wcnt_in  = '0;
            state_in = ST_SC_RD0;
         end
         ST_SC_RD0: begin
            pix_rd_addr = clamp_word(src_word);
            state_in    = ST_SC_RD1;
         end
         ST_SC_RD1: begin
            src0_in     = pix_rd_data;
            pix_rd_addr = clamp_word(src_word + BAW'(1));
            state_in    = ST_SC_RD2;
         end
         ST_SC_RD2: begin
            src1_in     = pix_rd_data;
            pix_rd_addr = wcnt_ff;
            state_in    = ST_SC_WR;
         end
         ST_SC_WR: begin
            // copy below keep, clear the band, hold bits past the screen
            pix_wr_en   = 1'b1;
            pix_wr_addr = wcnt_ff;
            pix_wr_data = (pair[WORD_BITS-1:0] & low_mask(wcnt_ff, keep_ff)) |
                          (pix_rd_data & ~low_mask(wcnt_ff, prod_ff));
            if (wcnt_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               wcnt_in  = wcnt_ff + PAW'(1);
               state_in = ST_SC_RD0;
            end
         end
         ST_RMUL: begin
            prod_in    = BAW'(req_ff.pixel_y) * BAW'(screen.width);
            inrange_in = (req_ff.pixel_x < screen.width) &&
                         (req_ff.pixel_y < screen.height);
            state_in   = ST_RRD;
         end
         ST_RRD: begin
            pix_rd_addr = clamp_word(read_base >> WORD_SHIFT);
            bit_in      = read_base[WORD_SHIFT-1:0];
            state_in    = ST_RDATA;
         end
         ST_RDATA: begin
            hit_in   = inrange_ff && pix_rd_data[bit_ff];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.cursor_col  = cx_ff;
               rsp_in.cursor_row  = cy_ff;
               rsp_in.pixel_color = hit_ff ? LIT_COLOR : '0;
               rsp_in.scrolled    = scrolled_ff;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         rsp_valid_ff <= 1'b0;
         wcnt_ff      <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wcnt_ff      <= wcnt_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      row_ff      <= row_in;
      prod_ff     <= prod_in;
      band_ff     <= band_in;
      keep_ff     <= keep_in;
      mask_ff     <= mask_in;
      word_ff     <= word_in;
      half_ff     <= half_in;
      rowok_ff    <= rowok_in;
      last_ff     <= last_in;
      src0_ff     <= src0_in;
      src1_ff     <= src1_in;
      inrange_ff  <= inrange_in;
      bit_ff      <= bit_in;
      hit_ff      <= hit_in;
      scrolled_ff <= scrolled_in;
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console renderer testbench
// Streams put-char, pixel read, glyph load and clear words through the
// console under several screen geometries, mirrors the pixel and glyph
// stores in a local console model and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
   import tcr_pkg::*;

   localparam int GW = GLYPH_WIDTH_DEF;
   localparam int GH = GLYPH_HEIGHT_DEF;
   localparam int MW = MAX_WIDTH_DEF;
   localparam int MH = MAX_HEIGHT_DEF;
   localparam int STORE_BITS = MW * MH;
   localparam int LONG_HOLD_AT = 140;
   localparam int LONG_HOLD_CYCLES = 400;
   // rows of the directed glyph, row 0 in the lowest byte
   localparam logic [127:0] DIRECTED_ROWS =
      128'hDB24_E718_7E81_3CC3_0FF0_55AA_0001_80FF;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_USER_BITS-1:0] req_tuser = '0;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_wr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   // console model
   bit                       screen_bits [0:STORE_BITS-1];
   logic [GBITS_BITS-1:0]    glyph_bytes [0:256*GH-1];
   int                       pen_col = 0;
   int                       pen_row = 0;
   int                       set_width = MW;
   int                       set_height = MH;

   // stimulus bookkeeping
   request_type              pending_words [$];
   response_type             expected_replies [$];
   request_type              live_word;
   bit [GH-1:0]              glyph_mask [0:255];
   bit                       code_ready [0:255];
   logic [CODE_BITS-1:0]     ready_codes [$];
   int                       words_offered = 0;
   int                       replies_seen = 0;
   int                       fault_count = 0;
   int                       scroll_total = 0;
   int                       lit_total = 0;
   int                       send_wait = 0;
   int                       rsp_wait = 0;
   bit                       steady_flow = 1'b0;

   text_console_renderer_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_index (csr_wr_index),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int screen_w();
      if (set_width < GW) return GW;
      if (set_width > MW) return MW;
      return set_width;
   endfunction

   function automatic int screen_h();
      if (set_height < GH) return GH;
      if (set_height > MH) return MH;
      return set_height;
   endfunction

   // Work out the reply to one word and advance the console model.
   function automatic response_type render_word(input request_type rq);
      response_type reply;
      logic [GBITS_BITS-1:0] bits;
      int w, h, code, px, py, r, c, i, keep, band;
      w = screen_w();
      h = screen_h();
      code = int'(rq.char_code);
      reply = '0;
      case (rq.action)
         ACT_PUT: begin
            if (rq.char_code == CODE_NEWLINE) begin
               pen_col = 0;
               pen_row += GH;
            end else if (rq.char_code == CODE_RETURN) begin
               pen_col = 0;
            end else begin
               for (r = 0; r < GH; r++) begin
                  bits = glyph_bytes[code * GH + r];
                  py = pen_row + r;
                  if (py < h) begin
                     for (c = 0; c < GW; c++) begin
                        px = pen_col + c;
                        if (bits[GLYPH_MSB - c] && px < w) screen_bits[py * w + px] = 1'b1;
                     end
                  end
               end
               pen_col += GW;
            end
            if (pen_col + GW > w) begin
               pen_col = 0;
               pen_row += GH;
            end
            if (pen_row + GH > h) begin
               // move everything up one text row, blank the bottom band
               keep = w * (h - GH);
               band = w * GH;
               for (i = 0; i < keep; i++) screen_bits[i] = screen_bits[i + band];
               for (i = keep; i < keep + band; i++) screen_bits[i] = 1'b0;
               pen_row = h - GH;
               reply.scrolled = 1'b1;
               scroll_total++;
            end
         end
         ACT_READ: begin
            px = int'(rq.pixel_x);
            py = int'(rq.pixel_y);
            if (px < w && py < h && screen_bits[py * w + px]) begin
               reply.pixel_color = LIT_COLOR;
               lit_total++;
            end
         end
         ACT_LOAD: begin
            if (rq.glyph_row < GH) glyph_bytes[code * GH + rq.glyph_row] = rq.glyph_bits;
         end
         default: begin
            for (i = 0; i < STORE_BITS; i++) screen_bits[i] = 1'b0;
            pen_col = 0;
            pen_row = 0;
         end
      endcase
      reply.cursor_col = COL_BITS'(pen_col);
      reply.cursor_row = ROW_BITS'(pen_row);
      return reply;
   endfunction

   // driver: present pending words, predict each one as it is taken
   always @(posedge clock) begin : drive
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(render_word(live_word));
            send_wait = steady_flow ? 0 : $urandom_range(0, 5);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait == 0 && pending_words.size() != 0) begin
               live_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= live_word.action;
               req_tdata <= {1'b0, live_word.glyph_bits, live_word.glyph_row,
                             live_word.pixel_y, live_word.pixel_x, live_word.char_code};
            end else begin
               req_tvalid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end
         end
      end
   end

   // monitor: take result words and compare with the oldest prediction
   always @(posedge clock) begin : watch
      response_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cursor_col  = rsp_tdata[9:0];
            got.cursor_row  = rsp_tdata[18:10];
            got.pixel_color = rsp_tdata[42:19];
            got.scrolled    = rsp_tdata[43];
            if (expected_replies.size() == 0) begin
               $error("result word arrived with no expectation waiting");
               fault_count++;
            end else begin
               want = expected_replies.pop_front();
               replies_seen++;
               if (got.cursor_col !== want.cursor_col) begin
                  $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
                  fault_count++;
               end
               if (got.cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                  fault_count++;
               end
               if (got.pixel_color !== want.pixel_color) begin
                  $error("pixel_color: expected %h, got %h", want.pixel_color,
                         got.pixel_color);
                  fault_count++;
               end
               if (got.scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                  fault_count++;
               end
            end
            // one long hold so the block fills up and backs off its input
            if (replies_seen == LONG_HOLD_AT) rsp_wait = LONG_HOLD_CYCLES;
            else rsp_wait = steady_flow ? 0 : $urandom_range(0, 5);
         end
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic request_type make_word(input action_type act, input int code,
                                             input int x, input int y, input int row,
                                             input int bits);
      request_type rq;
      rq.action     = act;
      rq.char_code  = CODE_BITS'(code);
      rq.pixel_x    = COL_BITS'(x);
      rq.pixel_y    = ROW_BITS'(y);
      rq.glyph_row  = GROW_BITS'(row);
      rq.glyph_bits = GBITS_BITS'(bits);
      return rq;
   endfunction

   function automatic request_type noise_word(input action_type act);
      return make_word(act, $urandom_range(0, 255), $urandom_range(0, 1023),
                       $urandom_range(0, 511), $urandom_range(0, 15), $urandom_range(0, 255));
   endfunction

   task automatic offer(input request_type rq);
      pending_words.push_back(rq);
      words_offered++;
      if (rq.action == ACT_LOAD) begin
         glyph_mask[rq.char_code][rq.glyph_row] = 1'b1;
         // a code may only be printed once all of its rows are loaded
         if (&glyph_mask[rq.char_code] && !code_ready[rq.char_code]) begin
            code_ready[rq.char_code] = 1'b1;
            ready_codes.push_back(rq.char_code);
         end
      end
   endtask

   task automatic offer_glyph(input int code);
      request_type rq;
      int r;
      for (r = 0; r < GH; r++) begin
         rq = noise_word(ACT_LOAD);
         rq.char_code = CODE_BITS'(code);
         rq.glyph_row = GROW_BITS'(r);
         offer(rq);
      end
   endtask

   task automatic queue_words(input int count, input int newline_pct, input int clear_at);
      request_type rq;
      int made, roll, w, h;
      w = screen_w();
      h = screen_h();
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (clear_at >= 0 && made >= clear_at) begin
            offer(noise_word(ACT_CLEAR));
            clear_at = -1;
            made++;
         end else if (made % 40 == 39) begin
            offer_glyph($urandom_range(0, 255));
            made += GH;
         end else if (roll < 55) begin
            rq = noise_word(ACT_PUT);
            roll = $urandom_range(0, 99);
            if (roll < newline_pct) rq.char_code = CODE_NEWLINE;
            else if (roll < newline_pct + 6 || ready_codes.size() == 0)
               rq.char_code = CODE_RETURN;
            else rq.char_code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
            offer(rq);
            made++;
         end else if (roll < 82) begin
            rq = noise_word(ACT_READ);
            // mostly aim at the top-left area where the text lands
            if ($urandom_range(0, 4) != 0) begin
               rq.pixel_x = COL_BITS'($urandom_range(0, (w < 128 ? w : 128) - 1));
               rq.pixel_y = ROW_BITS'($urandom_range(0, (h < 64 ? h : 64) - 1));
            end
            offer(rq);
            made++;
         end else begin
            offer(noise_word(ACT_LOAD));
            made++;
         end
      end
   endtask

   task automatic wait_idle();
      while (replies_seen < words_offered) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(input int width, input int height);
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_index <= REG_WIDTH;
      csr_wr_data  <= CSR_DATA_BITS'(width);
      @(posedge clock);
      csr_wr_index <= REG_HEIGHT;
      csr_wr_data  <= CSR_DATA_BITS'(height);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      set_width  = width;
      set_height = height;
   endtask

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: one full glyph at the top code, print, return, print, newline,
      // reads at the origin, inside the glyph, the far corner and beyond the screen, clear
      for (i = 0; i < GH; i++) offer(make_word(ACT_LOAD, 255, 0, 0, i, DIRECTED_ROWS[8*i +: 8]));
      offer(make_word(ACT_PUT, 255, 0, 0, 0, 0));
      offer(make_word(ACT_PUT, CODE_RETURN, 0, 0, 0, 0));
      offer(make_word(ACT_PUT, 255, 0, 0, 0, 0));
      offer(make_word(ACT_PUT, CODE_NEWLINE, 0, 0, 0, 0));
      offer(make_word(ACT_READ, 0, 0, 0, 0, 0));
      offer(make_word(ACT_READ, 0, 7, 1, 0, 0));
      offer(make_word(ACT_READ, 0, MW - 1, MH - 1, 0, 0));
      offer(make_word(ACT_READ, 0, 1023, 511, 0, 0));
      offer(make_word(ACT_CLEAR, 0, 0, 0, 0, 0));
      wait_idle();

      // small screen, frequent scrolls; drain halfway through
      set_geometry(64, 32);
      offer_glyph(0);
      queue_words(64, 8, -1);
      wait_idle();
      queue_words(80, 8, 30);
      wait_idle();

      // width below one glyph, height above the maximum
      set_geometry(0, 511);
      queue_words(80, 4, -1);
      wait_idle();

      // odd sizes with no idling on either side
      steady_flow = 1'b1;
      set_geometry(100, 40);
      queue_words(80, 8, -1);
      wait_idle();
      steady_flow = 1'b0;

      // width above the maximum, height below one glyph
      set_geometry(1023, 0);
      queue_words(60, 3, 45);
      wait_idle();

      set_geometry(MW, MH);
      queue_words(45, 6, -1);
      wait_idle();

      repeat (20) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $error("%0d expected result words never arrived", expected_replies.size());
         fault_count++;
      end
      $display("run covered %0d words over six screen geometries", words_offered);
      $display("%0d scrolls predicted, %0d lit pixels read back", scroll_total, lit_total);
      if (fault_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
